### rtl/dbspr_pkg.sv
package dbspr_pkg;

    // Field widths of the item and register set
    localparam int unsigned ELAPSED_W  = 16;
    localparam int unsigned ADC_W      = 12;
    localparam int unsigned DUTY_W     = 16;
    localparam int unsigned DEADBAND_W = 12;
    localparam int unsigned CYCLE_W    = 8;
    localparam int unsigned PERIOD_W   = 16;

    // Moving average: the tap count is a power of two so the mean is a shift
    localparam int unsigned AVG_SHIFT = 1;
    localparam int unsigned AVG_TAPS  = 1 << AVG_SHIFT;
    localparam int unsigned SLOT_W    = AVG_SHIFT;
    localparam int unsigned TOTAL_W   = DUTY_W + AVG_SHIFT;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEADBAND   = 2'd0,
        REG_CYCLE_MS   = 2'd1,
        REG_PWM_PERIOD = 2'd2
    } cfg_reg_t;

    // Register reset values
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 12'd16;
    localparam logic [CYCLE_W-1:0]    CYCLE_RST    = 8'd7;
    localparam logic [PERIOD_W-1:0]   PERIOD_RST   = 16'd160;

    // Per-channel status handed from a channel to the top level
    typedef struct packed {
        logic written;
        logic reached;
        logic stuck;
    } chan_status_t;

endpackage

### rtl/dbspr_chan.sv
module dbspr_chan (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                commit,
    input  logic                                step,
    input  logic [dbspr_pkg::ADC_W-1:0]         measured,
    input  logic [dbspr_pkg::ADC_W-1:0]         target,
    input  logic [dbspr_pkg::DEADBAND_W-1:0]    deadband,
    input  logic [dbspr_pkg::PERIOD_W-1:0]      pwm_period,
    output logic [dbspr_pkg::DUTY_W-1:0]        duty_next,
    output dbspr_pkg::chan_status_t             status
);

    logic [dbspr_pkg::DUTY_W-1:0]  compare_reg;
    logic [dbspr_pkg::DUTY_W-1:0]  hist_reg [dbspr_pkg::AVG_TAPS];
    logic [dbspr_pkg::TOTAL_W-1:0] total_reg;
    logic [dbspr_pkg::SLOT_W-1:0]  slot_reg;
    logic [dbspr_pkg::ADC_W-1:0]   last_target_reg;
    logic                          reached_reg;
    logic                          stuck_reg;

    logic [dbspr_pkg::DUTY_W-1:0]  work;
    logic [dbspr_pkg::TOTAL_W-1:0] total_next;
    logic [dbspr_pkg::DUTY_W-1:0]  avg;
    logic                          reached_next;
    logic                          stuck_next;
    logic                          below;
    logic                          above;
    logic                          write_en;

    // Band limits worked one bit wider so neither side wraps
    assign below = ({1'b0, measured} + {1'b0, deadband}) < {1'b0, target};
    assign above = {1'b0, measured} > ({1'b0, target} + {1'b0, deadband});

    always_comb begin
        // A new target drops both sticky flags before the step looks at them
        reached_next = (target != last_target_reg) ? 1'b0 : reached_reg;
        stuck_next   = (target != last_target_reg) ? 1'b0 : stuck_reg;
        work         = compare_reg;
        if (step) begin
            if (below) begin
                if (compare_reg < pwm_period) begin
                    work = compare_reg + 1'b1;
                end else begin
                    stuck_next = 1'b1;
                end
            end else if (above) begin
                if (compare_reg > dbspr_pkg::DUTY_W'(1)) begin
                    work = compare_reg - 1'b1;
                end else begin
                    stuck_next = 1'b1;
                end
            end else begin
                reached_next = 1'b1;
            end
        end
        total_next = total_reg - {{dbspr_pkg::AVG_SHIFT{1'b0}}, hist_reg[slot_reg]}
                   + {{dbspr_pkg::AVG_SHIFT{1'b0}}, work};
        avg        = total_next[dbspr_pkg::TOTAL_W-1:dbspr_pkg::AVG_SHIFT];
        write_en   = step && !reached_next && !stuck_next;
        duty_next  = write_en ? avg : compare_reg;
    end

    assign status.written = write_en;
    assign status.reached = reached_next;
    assign status.stuck   = stuck_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compare_reg     <= '0;
            total_reg       <= '0;
            slot_reg        <= '0;
            last_target_reg <= '0;
            reached_reg     <= 1'b0;
            stuck_reg       <= 1'b0;
            for (int t = 0; t < dbspr_pkg::AVG_TAPS; t++) begin
                hist_reg[t] <= '0;
            end
        end else if (commit) begin
            last_target_reg <= target;
            reached_reg     <= reached_next;
            stuck_reg       <= stuck_next;
            if (step) begin
                hist_reg[slot_reg] <= work;
                total_reg          <= total_next;
                slot_reg           <= slot_reg + 1'b1;
                compare_reg        <= duty_next;
            end
        end
    end

endmodule

### rtl/deadband_step_pwm_regulator_unit.sv
// Deadband step PWM regulator: two register stages, input and result.
// Items wait in the input register; their results are registered for the m_ side.
// Throughput: one item per cycle unless m_ stalls; the loops are the per-channel state
// update and the ms counter, both closing between the input and result registers.
// Reset (aresetn low, synchronous): both stages empty, counter, compare values,
// averages and flags zero, registers back to deadband 16, cycle 7 ms, period 160.
module deadband_step_pwm_regulator_unit #(
    parameter int unsigned CHANNELS = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dbspr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dbspr_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Tick items in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, low bit up: elapsed_ms[15:0], measured_0..measured_n-1 (12 bits each),
    // target_0..target_n-1 (12 bits each)
    input  logic [16+24*CHANNELS-1:0]         s_tdata,
    // Result items out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, low bit up: stepped, duty_0..duty_n-1 (16 bits each), write_mask,
    // reached_mask, stuck_mask (n bits each), zero fill to whole bytes
    output logic [((1+19*CHANNELS+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned IN_W     = 16 + 24 * CHANNELS;
    localparam int unsigned OUT_BITS = 1 + 19 * CHANNELS;
    localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int unsigned MEAS_LSB = dbspr_pkg::ELAPSED_W;
    localparam int unsigned TGT_LSB  = MEAS_LSB + dbspr_pkg::ADC_W * CHANNELS;
    localparam int unsigned MASK_LSB = 1 + dbspr_pkg::DUTY_W * CHANNELS;

    // ---------------------------------------------------------------
    // Configuration registers; a write is registered at the end of its handshake cycle
    // ---------------------------------------------------------------
    logic [dbspr_pkg::DEADBAND_W-1:0] deadband_reg;
    logic [dbspr_pkg::CYCLE_W-1:0]    cycle_ms_reg;
    logic [dbspr_pkg::PERIOD_W-1:0]   pwm_period_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg   <= dbspr_pkg::DEADBAND_RST;
            cycle_ms_reg   <= dbspr_pkg::CYCLE_RST;
            pwm_period_reg <= dbspr_pkg::PERIOD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (dbspr_pkg::cfg_reg_t'(cfg_index))
                dbspr_pkg::REG_DEADBAND: begin
                    deadband_reg <= cfg_data[dbspr_pkg::DEADBAND_W-1:0];
                end
                dbspr_pkg::REG_CYCLE_MS: begin
                    cycle_ms_reg <= cfg_data[dbspr_pkg::CYCLE_W-1:0];
                end
                dbspr_pkg::REG_PWM_PERIOD: begin
                    pwm_period_reg <= cfg_data[dbspr_pkg::PERIOD_W-1:0];
                end
                default: begin
                    // indexes beyond the register list: drop the write
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: the input stage refills whenever the result stage moves,
    // so the input stalls only while both stages hold an item and the
    // result waits
    // ---------------------------------------------------------------
    logic             in_valid_reg;
    logic [IN_W-1:0]  in_data_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_adv;
    logic             commit;

    assign out_adv  = !out_valid_reg || m_tready;
    assign commit   = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload needs no reset; hold it while the stage is stalled
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    // ---------------------------------------------------------------
    // Millisecond counter: saturating add, then compare against the cycle
    // ---------------------------------------------------------------
    logic [dbspr_pkg::ELAPSED_W-1:0] ms_count_reg;
    logic [dbspr_pkg::ELAPSED_W:0]   ms_sum;
    logic [dbspr_pkg::ELAPSED_W-1:0] ms_sat;
    logic                            step;

    assign ms_sum = {1'b0, ms_count_reg} + {1'b0, in_data_reg[dbspr_pkg::ELAPSED_W-1:0]};
    assign ms_sat = ms_sum[dbspr_pkg::ELAPSED_W] ? '1 : ms_sum[dbspr_pkg::ELAPSED_W-1:0];
    assign step   = ms_sat >= {{(dbspr_pkg::ELAPSED_W-dbspr_pkg::CYCLE_W){1'b0}}, cycle_ms_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_count_reg <= '0;
        end else if (commit) begin
            ms_count_reg <= step ? '0 : ms_sat;
        end
    end

    // ---------------------------------------------------------------
    // Channels: every one steps in the same tick
    // ---------------------------------------------------------------
    logic [dbspr_pkg::DUTY_W-1:0] duty_next [CHANNELS];
    dbspr_pkg::chan_status_t      chan_status [CHANNELS];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        dbspr_chan u_chan (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .commit     (commit),
            .step       (step),
            .measured   (in_data_reg[MEAS_LSB + dbspr_pkg::ADC_W*c +: dbspr_pkg::ADC_W]),
            .target     (in_data_reg[TGT_LSB + dbspr_pkg::ADC_W*c +: dbspr_pkg::ADC_W]),
            .deadband   (deadband_reg),
            .pwm_period (pwm_period_reg),
            .duty_next  (duty_next[c]),
            .status     (chan_status[c])
        );
    end

    // Pack the result item
    logic [OUT_W-1:0] out_word;

    always_comb begin
        out_word    = '0;
        out_word[0] = step;
        for (int c = 0; c < CHANNELS; c++) begin
            out_word[1 + dbspr_pkg::DUTY_W*c +: dbspr_pkg::DUTY_W] = duty_next[c];
            out_word[MASK_LSB + c]              = chan_status[c].written;
            out_word[MASK_LSB + CHANNELS + c]   = chan_status[c].reached;
            out_word[MASK_LSB + 2*CHANNELS + c] = chan_status[c].stuck;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_data_reg <= out_word;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A rewritten compare value only comes with a regulation step
    a_write_needs_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_data_reg[MASK_LSB +: CHANNELS] != '0) |-> out_data_reg[0])
        else $error("compare rewritten without a regulation step");

    // A step clears the millisecond counter
    a_step_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && step |=> ms_count_reg == '0)
        else $error("counter not cleared after a step");

    // A held input item is not lost while the result side stalls
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_adv |=> in_valid_reg && $stable(in_data_reg))
        else $error("stalled input item lost");

    // A stalled result is kept until taken
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result item changed");

endmodule

### tb/deadband_step_pwm_regulator_unit_test.sv
module deadband_step_pwm_regulator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH        = 3;
    localparam int HALF_CLK   = 4;
    localparam int RESET_LEN  = 7;
    localparam int HOLD_LEN   = 300;   // long receiver hold-off, in cycles
    localparam int STALL_MAX  = 4000;  // cycles without any handshake before giving up
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 180;
    localparam int REPORT_MAX = 10;

    // One tick item as it sits on s_tdata, low bits at the bottom
    typedef struct packed {
        logic [NCH-1:0][dbspr_pkg::ADC_W-1:0] target;
        logic [NCH-1:0][dbspr_pkg::ADC_W-1:0] measured;
        logic [dbspr_pkg::ELAPSED_W-1:0]      elapsed_ms;
    } tick_t;

    // One result item as it sits on m_tdata
    typedef struct packed {
        logic [5:0]                            fill;
        logic [NCH-1:0]                        stuck_mask;
        logic [NCH-1:0]                        reached_mask;
        logic [NCH-1:0]                        write_mask;
        logic [NCH-1:0][dbspr_pkg::DUTY_W-1:0] duty;
        logic                                  stepped;
    } result_t;

    // Tracks the regulator state and compares every result item against it
    class regulator_scoreboard;
        logic [dbspr_pkg::DEADBAND_W-1:0] reg_deadband;
        logic [dbspr_pkg::CYCLE_W-1:0]    reg_cycle;
        logic [dbspr_pkg::PERIOD_W-1:0]   reg_period;
        logic [dbspr_pkg::ELAPSED_W-1:0]  ms_acc;
        logic [dbspr_pkg::DUTY_W-1:0]     duty_now [NCH];
        logic [dbspr_pkg::DUTY_W-1:0]     tap [NCH][dbspr_pkg::AVG_TAPS];
        logic [dbspr_pkg::TOTAL_W-1:0]    tap_sum [NCH];
        logic [dbspr_pkg::SLOT_W-1:0]     tap_ptr [NCH];
        logic [dbspr_pkg::ADC_W-1:0]      held_target [NCH];
        bit                               reached [NCH];
        bit                               stuck [NCH];
        result_t                          expected_duty_items [$];
        int                               mismatches;

        function new();
            reg_deadband = dbspr_pkg::DEADBAND_RST;
            reg_cycle    = dbspr_pkg::CYCLE_RST;
            reg_period   = dbspr_pkg::PERIOD_RST;
            ms_acc       = '0;
            for (int c = 0; c < NCH; c++) begin
                duty_now[c]    = '0;
                tap_sum[c]     = '0;
                tap_ptr[c]     = '0;
                held_target[c] = '0;
                reached[c]     = 0;
                stuck[c]       = 0;
                for (int k = 0; k < dbspr_pkg::AVG_TAPS; k++)
                    tap[c][k] = '0;
            end
            mismatches = 0;
        endfunction

        function void set_reg(logic [dbspr_pkg::CFG_INDEX_W-1:0] index,
                              logic [dbspr_pkg::CFG_DATA_W-1:0] data);
            case (dbspr_pkg::cfg_reg_t'(index))
                dbspr_pkg::REG_DEADBAND:   reg_deadband = data[dbspr_pkg::DEADBAND_W-1:0];
                dbspr_pkg::REG_CYCLE_MS:   reg_cycle    = data[dbspr_pkg::CYCLE_W-1:0];
                dbspr_pkg::REG_PWM_PERIOD: reg_period   = data[dbspr_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_duty_items.size();
        endfunction

        // Advance the regulator by one tick and queue the result it must produce
        function void note_tick(tick_t t);
            result_t                         r;
            logic [dbspr_pkg::ELAPSED_W:0]   acc;
            logic [dbspr_pkg::DUTY_W-1:0]    work;
            logic [dbspr_pkg::SLOT_W-1:0]    p;
            int                              lo;
            int                              hi;
            int                              meas;

            r = '0;
            acc = {1'b0, ms_acc} + t.elapsed_ms;
            if (acc > 17'hFFFF)
                acc = 17'hFFFF;
            ms_acc = acc[dbspr_pkg::ELAPSED_W-1:0];

            for (int c = 0; c < NCH; c++) begin
                if (t.target[c] != held_target[c]) begin
                    held_target[c] = t.target[c];
                    reached[c]     = 0;
                    stuck[c]       = 0;
                end
            end

            r.stepped = (ms_acc >= reg_cycle);
            if (r.stepped) begin
                ms_acc = '0;
                for (int c = 0; c < NCH; c++) begin
                    meas = int'(t.measured[c]);
                    lo   = int'(held_target[c]) - int'(reg_deadband);
                    hi   = int'(held_target[c]) + int'(reg_deadband);
                    work = duty_now[c];
                    if (meas < lo) begin
                        if (work < reg_period)
                            work = work + 1'b1;
                        else
                            stuck[c] = 1;
                    end else if (meas > hi) begin
                        if (work > 1)
                            work = work - 1'b1;
                        else
                            stuck[c] = 1;
                    end else begin
                        reached[c] = 1;
                    end
                    // Two-tap running sum: drop the oldest tap, add the new one
                    p = tap_ptr[c];
                    tap_sum[c] = tap_sum[c] - tap[c][p] + work;
                    tap[c][p]  = work;
                    tap_ptr[c] = p + 1'b1;
                    if (!reached[c] && !stuck[c]) begin
                        duty_now[c] = tap_sum[c][dbspr_pkg::TOTAL_W-1:dbspr_pkg::AVG_SHIFT];
                        r.write_mask[c] = 1'b1;
                    end
                end
            end

            for (int c = 0; c < NCH; c++) begin
                r.duty[c]         = duty_now[c];
                r.reached_mask[c] = reached[c];
                r.stuck_mask[c]   = stuck[c];
            end
            expected_duty_items.push_back(r);
        endfunction

        function void compare_field(string name, logic [dbspr_pkg::DUTY_W-1:0] want,
                                    logic [dbspr_pkg::DUTY_W-1:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%t: %s mismatch, expected %0h, got %0h", $realtime, name,
                             want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_duty_items.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%t: result item %0h arrived with none expected", $realtime,
                             got);
                return;
            end
            want = expected_duty_items.pop_front();
            compare_field("stepped", dbspr_pkg::DUTY_W'(want.stepped),
                          dbspr_pkg::DUTY_W'(got.stepped));
            for (int c = 0; c < NCH; c++)
                compare_field($sformatf("duty_%0d", c), want.duty[c], got.duty[c]);
            compare_field("write_mask", dbspr_pkg::DUTY_W'(want.write_mask),
                          dbspr_pkg::DUTY_W'(got.write_mask));
            compare_field("reached_mask", dbspr_pkg::DUTY_W'(want.reached_mask),
                          dbspr_pkg::DUTY_W'(got.reached_mask));
            compare_field("stuck_mask", dbspr_pkg::DUTY_W'(want.stuck_mask),
                          dbspr_pkg::DUTY_W'(got.stuck_mask));
        endfunction
    endclass

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [dbspr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [dbspr_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [87:0]                       s_tdata;   // elapsed_ms, measured_0..2, target_0..2
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [63:0]                       m_tdata;   // stepped, duty_0..2, write/reached/stuck masks

    regulator_scoreboard sb;

    // Per-phase register settings, extremes and the degenerate ones among them
    int phase_deadband [PHASES] = '{16, 0, 4, 40, 4095, 8, 2, 100};
    int phase_cycle    [PHASES] = '{7, 1, 2, 3, 255, 0, 1, 4};
    int phase_period   [PHASES] = '{160, 3, 1, 0, 65535, 5, 2, 300};

    int                          cur_deadband;
    int                          cur_cycle;
    logic [dbspr_pkg::ADC_W-1:0] cur_target [NCH];
    int                          sender_idle_pct;
    int                          recv_stall_pct;
    bit                          hold_req = 1'b0;
    bit                          hold_done = 1'b0;
    int                          hold_left = 0;
    int                          quiet_cycles = 0;

    deadband_step_pwm_regulator_unit #(
        .CHANNELS(NCH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_CLK aclk = ~aclk;

    // Note every accepted item and register write, and check every taken result, at the edge that accepts it
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_tick(tick_t'(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_result(result_t'(m_tdata));
        end
    end

    // Watchdog: give up after a long run of cycles in which nothing moves
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic tick_t make_tick(int elapsed, int m0, int m1, int m2,
                                        int t0, int t1, int t2);
        tick_t t;
        t.elapsed_ms  = dbspr_pkg::ELAPSED_W'(elapsed);
        t.measured[0] = dbspr_pkg::ADC_W'(m0);
        t.measured[1] = dbspr_pkg::ADC_W'(m1);
        t.measured[2] = dbspr_pkg::ADC_W'(m2);
        t.target[0]   = dbspr_pkg::ADC_W'(t0);
        t.target[1]   = dbspr_pkg::ADC_W'(t1);
        t.target[2]   = dbspr_pkg::ADC_W'(t2);
        return t;
    endfunction

    // Mostly steady targets with measurements around the band; some noise
    function automatic tick_t random_tick();
        tick_t t;
        int    span;
        int    m;
        int    pick;

        pick = $urandom_range(0, 99);
        if (pick < 75)
            t.elapsed_ms = dbspr_pkg::ELAPSED_W'($urandom_range(0, 3));
        else if (pick < 88)
            t.elapsed_ms = dbspr_pkg::ELAPSED_W'($urandom_range(0, 2 * cur_cycle + 1));
        else if (pick < 95)
            t.elapsed_ms = dbspr_pkg::ELAPSED_W'($urandom_range(0, 65535));
        else
            t.elapsed_ms = 16'hFFFF;

        span = 2 * cur_deadband + 3;
        for (int c = 0; c < NCH; c++) begin
            if ($urandom_range(0, 99) < 4) begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    cur_target[c] = '0;
                else if (pick < 30)
                    cur_target[c] = '1;
                else
                    cur_target[c] = dbspr_pkg::ADC_W'($urandom_range(0, 4095));
            end
            t.target[c] = cur_target[c];
            if ($urandom_range(0, 99) < 85) begin
                m = int'(cur_target[c]) + int'($urandom_range(0, 2 * span)) - span;
                if (m < 0)
                    m = 0;
                if (m > 4095)
                    m = 4095;
            end else begin
                m = $urandom_range(0, 4095);
            end
            t.measured[c] = dbspr_pkg::ADC_W'(m);
        end
        return t;
    endfunction

    // Offer one item after a random gap; return at the falling edge after acceptance
    task automatic send_tick(tick_t t);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Hold valid high across back-to-back writes; the caller lowers it afterwards
    task automatic write_reg(dbspr_pkg::cfg_reg_t index, int value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= dbspr_pkg::CFG_DATA_W'(value);
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apply_setting(int deadband, int cycle, int period);
        write_reg(dbspr_pkg::REG_DEADBAND, deadband);
        write_reg(dbspr_pkg::REG_CYCLE_MS, cycle);
        write_reg(dbspr_pkg::REG_PWM_PERIOD, period);
        cfg_valid    <= 1'b0;
        cur_deadband = deadband;
        cur_cycle    = cycle;
    endtask

    // Stop offering and wait until every expected result item has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin sender_idle_pct = 20; recv_stall_pct = 20; end
        endcase
    endtask

    initial begin
        sb = new();
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        cur_deadband    = dbspr_pkg::DEADBAND_RST;
        cur_cycle       = dbspr_pkg::CYCLE_RST;
        for (int c = 0; c < NCH; c++)
            cur_target[c] = '0;

        repeat (RESET_LEN) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: field extremes, a counter sum at its maximum, targets changing
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(65535, 4095, 4095, 4095, 4095, 4095, 4095));
        send_tick(make_tick(7, 0, 0, 0, 4094, 4094, 4094));
        send_tick(make_tick(16'hAAAA, 4095, 2730, 1365, 0, 2730, 1365));
        send_tick(make_tick(6, 1365, 0, 4095, 0, 2730, 1365));
        send_tick(make_tick(16'h5555, 1365, 0, 4095, 0, 2730, 1365));

        // Zero band and cycle, tiny period: hit the top and the bottom and get stuck
        drain();
        apply_setting(0, 0, 2);
        for (int i = 0; i < 6; i++)
            send_tick(make_tick(0, 0, 4095, 5, 1, 4094, 5));

        // Period below two: a compare value at or above it cannot rise
        drain();
        apply_setting(0, 0, 0);
        send_tick(make_tick(3, 0, 0, 7, 9, 8, 7));
        send_tick(make_tick(0, 0, 4095, 7, 9, 8, 7));
        send_tick(make_tick(1, 4095, 0, 6, 9, 8, 7));

        // Widest band, longest cycle: the band runs past both ends of the ADC range
        drain();
        apply_setting(4095, 255, 65535);
        send_tick(make_tick(65535, 0, 4095, 2048, 4095, 0, 2047));
        send_tick(make_tick(65535, 4095, 0, 0, 4095, 0, 2047));
        send_tick(make_tick(254, 0, 0, 4095, 0, 4095, 2048));

        // Random phases, each with its own register setting and idling pattern
        for (int p = 0; p < PHASES; p++) begin
            drain();
            apply_setting(phase_deadband[p], phase_cycle[p], phase_period[p]);
            set_idling(p % 4);
            // Keep offering while the receiver holds off so the input backs up
            if (p == 4)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_LEN; i++)
                send_tick(random_tick());
        end

        drain();
        repeat (4) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### deadband_step_pwm_regulator_unit.f
rtl/dbspr_pkg.sv
rtl/dbspr_chan.sv
rtl/deadband_step_pwm_regulator_unit.sv
tb/deadband_step_pwm_regulator_unit_test.sv
